[sv/assert_macros.svh]
// Assertion macros for the hull block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[sv/chull_pkg.sv]
package chull_pkg;
   localparam int MAX_POINTS_DEF = 32;
   localparam int COORD_BITS_DEF = 16;
   localparam int FIELD_BITS = COORD_BITS_DEF;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] px;
      logic signed [FIELD_BITS-1:0] py;
      logic                         final_point;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] hx;
      logic signed [FIELD_BITS-1:0] hy;
      logic                         last_vertex;
      logic                         overflowed;
   } rsp_type;
endpackage

[sv/convex_hull_monotone_chain_top.sv]
// Flow: a stored point is put in order by insertion, each shift a read (ST_INSRD),
// then a write (ST_INS); a point that finds the store full is dropped. A final point
// then runs both hull passes through one shared multiplier: a turn test loads three
// points, forms both products and compares them; then the vertices are sent out.
// Throughput: one request at a time; ready is low while a request is worked on.
// Reset: synchronous, active high; clears count, stack top, drop flag, response valid and sequencer.
`include "assert_macros.svh"
module convex_hull_monotone_chain_top
   import chull_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int COORD_BITS = COORD_BITS_DEF;
   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int SD = 2 * MAX_POINTS;
   localparam int SW = $clog2(SD);
   localparam int TW = $clog2(SD + 1);
   localparam int PW = 2 * COORD_BITS + 2;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_INS   = 4'd1;
   localparam logic [3:0] ST_INSRD = 4'd2;
   localparam logic [3:0] ST_NEXT  = 4'd3;
   localparam logic [3:0] ST_TEST  = 4'd4;
   localparam logic [3:0] ST_RD    = 4'd5;
   localparam logic [3:0] ST_M1    = 4'd6;
   localparam logic [3:0] ST_M2    = 4'd7;
   localparam logic [3:0] ST_DEC   = 4'd8;
   localparam logic [3:0] ST_OUTRD = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;
   localparam logic [3:0] ST_LDA   = 4'd11;
   localparam logic [3:0] ST_LDB   = 4'd12;
   localparam logic [3:0] ST_LDC   = 4'd13;

   // Point store and index stack.
   logic [2*COORD_BITS-1:0] store_mem [MAX_POINTS];
   logic [IW-1:0]           stack_mem [SD];

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] top_ff, top_in;
   logic        drop_ff, drop_in;
   logic        fin_ff, fin_in;
   logic        back_ff, back_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [TW-1:0] k_ff, k_in;
   logic signed [COORD_BITS-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [2*COORD_BITS-1:0] rd_ff;
   logic [IW-1:0] rd_addr;
   logic          st_we;
   logic [IW-1:0] st_addr;
   logic [2*COORD_BITS-1:0] st_wd;
   logic [IW-1:0] sk_rd_ff;
   logic [SW-1:0] sk_raddr;
   logic          sk_we;
   logic [SW-1:0] sk_waddr;
   logic signed [COORD_BITS-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [COORD_BITS:0] ma, mb;
   logic signed [PW-1:0] prod, c1_ff, c1_in;
   logic [1:0] sel_ff, sel_in;
   logic signed [COORD_BITS-1:0] rx, ry;
   logic insert_less;
   logic ovf_out;
   rsp_type rsp_ff, rsp_in;
   logic rsp_v_ff, rsp_v_in;

   assign rx = rd_ff[2*COORD_BITS-1:COORD_BITS];
   assign ry = rd_ff[COORD_BITS-1:0];

   // Memories with registered reads.
   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_addr] <= st_wd;
      rd_ff <= store_mem[rd_addr];
      if (sk_we) stack_mem[sk_waddr] <= cur_ff;
      sk_rd_ff <= stack_mem[sk_raddr];
   end

   chull_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock(clock), .op_a(ma), .op_b(mb), .prod(prod)
   );

   assign insert_less = (nx_ff != rx) ? (nx_ff < rx) : (ny_ff < ry);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;
   assign ovf_out   = drop_ff;

   // Sequencer.
   always_comb begin
      state_in = state_ff; count_in = count_ff; top_in = top_ff; drop_in = drop_ff;
      fin_in = fin_ff; back_in = back_ff; pos_in = pos_ff; cur_in = cur_ff; k_in = k_ff;
      nx_in = nx_ff; ny_in = ny_ff; ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff;
      by_in = by_ff; c1_in = c1_ff; sel_in = sel_ff;
      rsp_in = rsp_ff; rsp_v_in = rsp_v_ff;
      rd_addr = '0; st_we = 1'b0; st_addr = '0; st_wd = '0;
      sk_raddr = '0; sk_we = 1'b0; sk_waddr = '0;
      ma = '0; mb = '0;
      if (rsp_v_ff && rsp_ready) rsp_v_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               nx_in = req_data.px[COORD_BITS-1:0];
               ny_in = req_data.py[COORD_BITS-1:0];
               fin_in = req_data.final_point;
               pos_in = count_ff;
               if (count_ff == CW'(MAX_POINTS)) begin
                  drop_in = 1'b1;
                  state_in = ST_NEXT;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = ST_INSRD;
               end
            end
         end
         ST_INSRD: begin
            rd_addr = IW'(pos_ff - 1'b1);
            state_in = ST_INS;
         end
         ST_INS: begin
            // Shift one larger neighbour up, or place the new point.
            st_we = 1'b1;
            st_addr = IW'(pos_ff);
            if (pos_ff != '0 && insert_less) begin
               st_wd = rd_ff;
               pos_in = pos_ff - 1'b1;
               state_in = ST_INSRD;
            end else begin
               st_wd = {nx_ff, ny_ff};
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            // Start the hull, or go back to loading.
            if (!fin_ff) state_in = ST_IDLE;
            else begin
               top_in = '0; back_in = 1'b0; cur_in = '0;
               if (count_ff == '0) state_in = ST_DEC;
               else state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            // Push loop: test two top entries against cur.
            if (top_ff >= TW'(2)) begin
               sk_raddr = SW'(top_ff - TW'(2));
               sel_in = 2'd0;
               state_in = ST_LDA;
            end else begin
               sk_we = 1'b1;
               sk_waddr = SW'(top_ff);
               top_in = top_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_LDA: begin
            rd_addr = sk_rd_ff;
            sk_raddr = SW'(top_ff - TW'(1));
            state_in = ST_LDB;
         end
         ST_LDB: begin
            ax_in = rx; ay_in = ry;
            rd_addr = sk_rd_ff;
            state_in = ST_LDC;
         end
         ST_LDC: begin
            bx_in = rx; by_in = ry;
            rd_addr = cur_ff;
            state_in = ST_M1;
         end
         ST_M1: begin
            // (bx-ax)*(cy-ay), then (cx-ax)*(by-ay).
            ma = (COORD_BITS+1)'(bx_ff) - (COORD_BITS+1)'(ax_ff);
            mb = (COORD_BITS+1)'(ry) - (COORD_BITS+1)'(ay_ff);
            nx_in = rx; ny_in = ry;
            state_in = ST_M2;
         end
         ST_M2: begin
            ma = (COORD_BITS+1)'(nx_ff) - (COORD_BITS+1)'(ax_ff);
            mb = (COORD_BITS+1)'(by_ff) - (COORD_BITS+1)'(ay_ff);
            c1_in = prod;
            sel_in = 2'd1;
            state_in = ST_RD;
         end
         ST_RD: begin
            if (sel_ff == 2'd1) begin
               sel_in = 2'd0;
               if (c1_ff > prod) begin
                  top_in = top_ff - 1'b1;
                  state_in = ST_TEST;
               end else begin
                  sk_we = 1'b1;
                  sk_waddr = SW'(top_ff);
                  top_in = top_ff + 1'b1;
                  state_in = ST_DEC;
               end
            end else state_in = ST_DEC;
         end
         ST_DEC: begin
            // Advance the pass index.
            if (count_ff == '0) begin
               state_in = ST_OUTRD; k_in = '0;
            end else if (!back_ff) begin
               if (CW'(cur_ff) + 1'b1 < count_ff) begin
                  cur_in = cur_ff + 1'b1;
                  state_in = ST_TEST;
               end else begin
                  back_in = 1'b1;
                  if (cur_ff == '0) begin
                     state_in = ST_OUTRD; k_in = '0;
                  end else begin
                     cur_in = cur_ff - 1'b1;
                     state_in = ST_TEST;
                  end
               end
            end else if (cur_ff != '0) begin
               cur_in = cur_ff - 1'b1;
               state_in = ST_TEST;
            end else begin
               if (count_ff > CW'(1)) top_in = top_ff - 1'b1;
               k_in = '0;
               state_in = ST_OUTRD;
            end
         end
         ST_OUTRD: begin
            sk_raddr = SW'(k_ff);
            if (k_ff == top_ff) begin
               count_in = '0; top_in = '0; drop_in = 1'b0;
               state_in = ST_IDLE;
            end else state_in = ST_OUT;
         end
         ST_OUT: begin
            // Keep the stack entry addressed so the vertex read holds through a stall.
            sk_raddr = SW'(k_ff);
            rd_addr = sk_rd_ff;
            if (sel_ff != 2'd2) begin
               sel_in = 2'd2;
            end else if (!rsp_v_ff || rsp_ready) begin
               rsp_in.hx = FIELD_BITS'(signed'(rx));
               rsp_in.hy = FIELD_BITS'(signed'(ry));
               rsp_in.last_vertex = (k_ff + 1'b1 == top_ff);
               rsp_in.overflowed = ovf_out;
               rsp_v_in = 1'b1;
               sel_in = 2'd0;
               k_in = k_ff + 1'b1;
               state_in = ST_OUTRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; top_ff <= '0; drop_ff <= 1'b0;
         rsp_v_ff <= 1'b0; sel_ff <= 2'd0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; top_ff <= top_in;
         drop_ff <= drop_in; rsp_v_ff <= rsp_v_in; sel_ff <= sel_in;
      end
      fin_ff <= fin_in; back_ff <= back_in; pos_ff <= pos_in; cur_ff <= cur_in;
      k_ff <= k_in; nx_ff <= nx_in; ny_ff <= ny_in; ax_ff <= ax_in; ay_ff <= ay_in;
      bx_ff <= bx_in; by_ff <= by_in; c1_ff <= c1_in; rsp_ff <= rsp_in;
   end

   `ASSERT_IMPL(a_cnt_max, clock, reset, count_ff <= CW'(MAX_POINTS), "count overflow")
   `ASSERT_IMPL(a_top_max, clock, reset, top_ff <= TW'(SD), "stack overflow")
   `ASSERT_IMPL(a_rdy_idle, clock, reset, req_ready |-> state_ff == ST_IDLE, "ready busy")
endmodule

[sv/chull_cross.sv]
// Shared multiplier: one signed product per cycle, registered.
module chull_cross
   import chull_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic signed [COORD_BITS:0]    op_a,
   input  logic signed [COORD_BITS:0]    op_b,
   output logic signed [2*COORD_BITS+1:0] prod
);
   logic signed [2*COORD_BITS+1:0] prod_ff;

   // One multiply, one register.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;
endmodule

[dv/tb_convex_hull_monotone_chain_top.sv]
`timescale 1ns / 100ps
module tb_convex_hull_monotone_chain_top;
   import chull_pkg::*;

   localparam int CAP = MAX_POINTS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES = 600;

   logic    clock;
   logic    reset;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   convex_hull_monotone_chain_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Requests waiting to be driven, and hull vertices still to arrive.
   req_type pending_points[$];
   rsp_type expected_vertices[$];

   // Predictor state: the sorted point set of the current run.
   logic signed [15:0] sorted_x[CAP];
   logic signed [15:0] sorted_y[CAP];
   int                 stored_count = 0;
   bit                 points_dropped = 1'b0;

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_off;
   bit  pressure_start;
   bit  req_accepted;
   bit  failed = 1'b0;
   int  quiet_cycles = 0;
   int  accepted_points = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // True when the turn a -> b -> c bends strictly to the left.
   function automatic bit turns_left(int a, int b, int c);
      longint c1, c2;
      c1 = (longint'(sorted_x[b]) - sorted_x[a]) * (longint'(sorted_y[c]) - sorted_y[a]);
      c2 = (longint'(sorted_x[c]) - sorted_x[a]) * (longint'(sorted_y[b]) - sorted_y[a]);
      return (c1 - c2) > 0;
   endfunction

   // Insert a point in x-then-y order; on a final point work out the hull vertices.
   task automatic predict_hull(req_type pt);
      int chain[2*CAP];
      int depth;
      int i;
      int n;
      int k;
      rsp_type v;
      if (stored_count >= CAP) begin
         points_dropped = 1'b1;
      end else begin
         i = stored_count;
         while (i > 0 && (pt.px < sorted_x[i-1] ||
                (pt.px == sorted_x[i-1] && pt.py < sorted_y[i-1]))) begin
            sorted_x[i] = sorted_x[i-1];
            sorted_y[i] = sorted_y[i-1];
            i--;
         end
         sorted_x[i] = pt.px;
         sorted_y[i] = pt.py;
         stored_count++;
      end
      if (!pt.final_point) return;
      n = stored_count;
      depth = 0;
      if (n > 0) begin
         chain[depth] = 0;
         depth++;
         for (i = 1; i < n; i++) begin
            while (depth >= 2 && turns_left(chain[depth-2], chain[depth-1], i))
               depth--;
            chain[depth] = i;
            depth++;
         end
         for (i = n - 2; i >= 0; i--) begin
            while (depth >= 2 && turns_left(chain[depth-2], chain[depth-1], i))
               depth--;
            chain[depth] = i;
            depth++;
         end
         if (n > 1) depth--;
      end
      for (k = 0; k < depth; k++) begin
         v.hx = sorted_x[chain[k]];
         v.hy = sorted_y[chain[k]];
         v.last_vertex = (k == depth - 1);
         v.overflowed = points_dropped;
         expected_vertices.insert(expected_vertices.size(), v);
      end
      stored_count = 0;
      points_dropped = 1'b0;
   endtask

   function automatic req_type make_point(int x, int y, bit fin);
      req_type r;
      r.px = 16'(x);
      r.py = 16'(y);
      r.final_point = fin;
      return r;
   endfunction

   // Append one point to the driver queue.
   task automatic add_point(int x, int y, bit fin);
      pending_points.insert(pending_points.size(), make_point(x, y, fin));
   endtask

   // Random coordinate: half the time a narrow range, so that collinear and duplicate points occur.
   function automatic int rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 65535) - 32768;
         1: return ($urandom_range(0, 1) ? 32767 : -32768);
         default: return $urandom_range(0, 8) - 4;
      endcase
   endfunction

   task automatic queue_random_set(int size);
      for (int i = 0; i < size; i++)
         add_point(rand_coord(), rand_coord(), i == size - 1);
   endtask

   // Remember whether the request on offer was taken at the last rising edge.
   always @(posedge clock) begin
      req_accepted <= req_valid && req_ready;
   end

   // Driver: offers requests at the falling edge and holds them until accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         req_valid <= 1'b1;
      end else if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         req_data <= pending_points.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver readiness, with an optional long hold-off.
   always @(negedge clock) begin
      if (reset || hold_off)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Long receiver hold-off, counted here, once the pressure sets are under way.
   initial begin
      hold_off = 1'b0;
      wait (pressure_start);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off = 1'b0;
   end

   // Monitor: predicts on each accepted request and checks each accepted vertex.
   always @(posedge clock) begin
      rsp_type exp_v;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_hull(req_data);
            accepted_points++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_vertices.size() == 0) begin
               $display("%0t: unexpected vertex, expected none, got %p", $realtime, rsp_data);
               failed = 1'b1;
            end else begin
               exp_v = expected_vertices.pop_front();
               if (rsp_data !== exp_v) begin
                  $display("%0t: vertex mismatch, expected %p, got %p",
                           $realtime, exp_v, rsp_data);
                  failed = 1'b1;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("convex_hull_monotone_chain_top regression: fail");
            $finish;
         end
      end
   end

   // Wait for the driver queue to empty and the last request to be accepted.
   task automatic drain_requests();
      while (pending_points.size() > 0 || req_valid) @(posedge clock);
   endtask

   // Stimulus and end of run.
   initial begin
      pressure_start = 1'b0;
      send_idle_pct = 9;
      recv_idle_pct = 66;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed sets: single point, extreme corners with a centre, collinear line, duplicates, mixed set.
      add_point(-32768, 32767, 1);
      add_point(32767, -32768, 0);
      add_point(-32768, -32768, 0);
      add_point(32767, 32767, 0);
      add_point(-32768, 32767, 0);
      add_point(0, 0, 1);
      for (int i = 0; i < 4; i++) add_point(i, i, i == 3);
      add_point(5, 5, 0);
      add_point(5, 5, 1);
      add_point(3, -2, 0);
      add_point(-1, -1, 0);
      add_point(3, -2, 0);
      add_point(-21846, 21845, 0);
      add_point(21845, -21846, 1);

      // Overflowing set: the store fills, then more points and a dropped final point.
      for (int i = 0; i < CAP + 3; i++)
         add_point(rand_coord(), rand_coord(), i == CAP + 2);

      // Pressure: hold the receiver off while several sets are offered.
      pressure_start = 1'b1;
      for (int s = 0; s < 4; s++) queue_random_set($urandom_range(3, 8));
      drain_requests();

      // Random sets across three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 66 : 0;
         recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 9 : 0;
         for (int cnt = 0; cnt < 125;) begin
            int sz;
            sz = ($urandom_range(0, 19) == 0) ? $urandom_range(CAP - 2, CAP + 2)
                                              : $urandom_range(1, 8);
            queue_random_set(sz);
            cnt += sz;
         end
         drain_requests();
      end

      while (expected_vertices.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed && expected_vertices.size() == 0)
         $display("convex_hull_monotone_chain_top regression: pass");
      else
         $display("convex_hull_monotone_chain_top regression: fail");
      $finish;
   end
endmodule
